FILE: sv/gtg_pkg.sv
// Shared constants, types and functions of the go-to-goal controller.
package gtg_pkg;

   localparam int CordicIters = 16;
   localparam int SqrtSteps   = 18;
   localparam int SqrtPerStg  = 2;
   localparam int SqrtStages  = SqrtSteps / SqrtPerStg;

   localparam logic signed [15:0] GoalXReset = 16'sd256;
   localparam logic signed [15:0] GoalYReset = 16'sd256;
   localparam logic [15:0]        TolReset   = 16'd3;

   localparam logic [1:0] RegGoalX = 2'd0;
   localparam logic [1:0] RegGoalY = 2'd1;
   localparam logic [1:0] RegTol   = 2'd2;

   localparam logic signed [27:0] HalfPiQ16 = 28'sd102944;
   localparam logic [17:0]        LinMax    = 18'd262143;
   localparam logic signed [20:0] AngMax    = 21'sd262143;
   localparam logic signed [20:0] AngMin    = -21'sd262144;

   function automatic logic signed [27:0] atan_q16(input logic [3:0] idx);
      logic signed [27:0] v;
      case (idx)
         4'd0:    v = 28'sd51472;
         4'd1:    v = 28'sd30386;
         4'd2:    v = 28'sd16055;
         4'd3:    v = 28'sd8150;
         4'd4:    v = 28'sd4091;
         4'd5:    v = 28'sd2047;
         4'd6:    v = 28'sd1024;
         4'd7:    v = 28'sd512;
         4'd8:    v = 28'sd256;
         4'd9:    v = 28'sd128;
         4'd10:   v = 28'sd64;
         4'd11:   v = 28'sd32;
         4'd12:   v = 28'sd16;
         4'd13:   v = 28'sd8;
         4'd14:   v = 28'sd4;
         default: v = 28'sd2;
      endcase
      return v;
   endfunction

   // Vector travelling through the CORDIC chain.
   typedef struct packed {
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic signed [27:0] z;
   } cordic_type;

   // Root extraction state: remainder, partial root, remaining radicand bits.
   typedef struct packed {
      logic [19:0] rem;
      logic [17:0] root;
      logic [35:0] rad;
   } sqrt_type;

   // Per-item side data that rides the pipeline alongside the vector.
   typedef struct packed {
      logic               arrived;
      logic signed [15:0] heading;
   } side_type;

endpackage

FILE: sv/gtg_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation with a root step while digits remain.
module gtg_cordic_stage #(
   parameter int Iter = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  gtg_pkg::cordic_type  in_vec,
   input  gtg_pkg::sqrt_type    in_sqrt,
   input  gtg_pkg::side_type    in_side,
   output logic                 out_valid,
   output gtg_pkg::cordic_type  out_vec,
   output gtg_pkg::sqrt_type    out_sqrt,
   output gtg_pkg::side_type    out_side
);

   logic                valid_ff;
   gtg_pkg::cordic_type vec_ff, vec_in;
   gtg_pkg::sqrt_type   sqrt_ff, sqrt_in;
   gtg_pkg::side_type   side_ff;
   logic signed [27:0]  xs, ys;
   logic [19:0]         trial;
   logic [19:0]         rem_sh;

   always_comb begin
      xs = in_vec.x >>> Iter;
      ys = in_vec.y >>> Iter;
      vec_in = in_vec;
      if (in_vec.y > 0) begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + gtg_pkg::atan_q16(4'(Iter));
      end else begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - gtg_pkg::atan_q16(4'(Iter));
      end
      // one restoring square-root digit per stage while digits remain
      sqrt_in = in_sqrt;
      rem_sh  = {in_sqrt.rem[17:0], in_sqrt.rad[35:34]};
      trial   = {in_sqrt.root, 2'b01};
      if (Iter < gtg_pkg::SqrtStages) begin
         sqrt_in.rad = {in_sqrt.rad[33:0], 2'b00};
         if (rem_sh >= trial) begin
            sqrt_in.rem  = rem_sh - trial;
            sqrt_in.root = {in_sqrt.root[16:0], 1'b1};
         end else begin
            sqrt_in.rem  = rem_sh;
            sqrt_in.root = {in_sqrt.root[16:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      vec_ff  <= vec_in;
      sqrt_ff <= sqrt_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_sqrt  = sqrt_ff;
   assign out_side  = side_ff;

endmodule

FILE: sv/gtg_front.sv
// Entry stages: goal offsets, squared distance, arrival test and pre-rotation.
module gtg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [15:0]   pose_x,
   input  logic signed [15:0]   pose_y,
   input  logic signed [15:0]   pose_heading,
   input  logic signed [15:0]   goal_x,
   input  logic signed [15:0]   goal_y,
   input  logic [15:0]          tol,
   output logic                 out_valid,
   output gtg_pkg::cordic_type  out_vec,
   output gtg_pkg::sqrt_type    out_sqrt,
   output gtg_pkg::side_type    out_side
);

   // stage A: offsets and squares
   logic               va_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic signed [15:0] hd_a_ff;
   logic [31:0]        tsq_ff;
   logic signed [16:0] dx_in, dy_in;
   // stage B: sum of squares
   logic               vb_ff;
   logic [33:0]        sq_ff;
   logic [31:0]        tsq_b_ff;
   logic signed [16:0] dx_b_ff, dy_b_ff;
   logic signed [15:0] hd_b_ff;
   logic [32:0]        dxx, dyy;
   // stage C: tolerance compare and pre-rotation
   logic                valid_ff;
   gtg_pkg::cordic_type vec_ff, vec_in;
   gtg_pkg::sqrt_type   sqrt_ff;
   gtg_pkg::side_type   side_ff;
   logic signed [27:0]  x0, y0;

   assign dx_in = 17'(goal_x) - 17'(pose_x);
   assign dy_in = 17'(goal_y) - 17'(pose_y);
   // widen before squaring so the product keeps all of its bits
   assign dxx   = 33'($unsigned(34'(dx_ff) * 34'(dx_ff)));
   assign dyy   = 33'($unsigned(34'(dy_ff) * 34'(dy_ff)));

   always_comb begin
      x0 = 28'(dx_b_ff) <<< 8;
      y0 = 28'(dy_b_ff) <<< 8;
      vec_in.x = x0;
      vec_in.y = y0;
      vec_in.z = '0;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            vec_in.x = y0;
            vec_in.y = -x0;
            vec_in.z = gtg_pkg::HalfPiQ16;
         end else begin
            vec_in.x = -y0;
            vec_in.y = x0;
            vec_in.z = -gtg_pkg::HalfPiQ16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         va_ff    <= in_valid;
         vb_ff    <= va_ff;
         valid_ff <= vb_ff;
      end
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      hd_a_ff  <= pose_heading;
      tsq_ff   <= tol * tol;
      sq_ff    <= 34'(dxx) + 34'(dyy);
      tsq_b_ff <= tsq_ff;
      dx_b_ff  <= dx_ff;
      dy_b_ff  <= dy_ff;
      hd_b_ff  <= hd_a_ff;
      vec_ff   <= vec_in;
      sqrt_ff.rem  <= '0;
      sqrt_ff.root <= '0;
      sqrt_ff.rad  <= {2'b00, sq_ff};
      side_ff.arrived <= (sq_ff <= 34'(tsq_b_ff));
      side_ff.heading <= hd_b_ff;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_sqrt  = sqrt_ff;
   assign out_side  = side_ff;

endmodule

FILE: sv/gtg_back.sv
// Exit stage: bearing rounding, gains, saturation and arrival masking.
module gtg_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  gtg_pkg::cordic_type  in_vec,
   input  gtg_pkg::sqrt_type    in_sqrt,
   input  gtg_pkg::side_type    in_side,
   output logic                 out_valid,
   output logic [17:0]          linear_cmd,
   output logic signed [18:0]   angular_cmd,
   output logic                 arrived
);

   logic               valid_ff;
   logic [17:0]        lin_ff, lin_in;
   logic signed [18:0] ang_ff, ang_in;
   logic               arr_ff;
   logic [19:0]        lin_w;
   logic signed [27:0] brg;
   logic signed [20:0] ang_w;

   always_comb begin
      lin_w = 20'((21'(in_sqrt.root) * 21'd3) >> 1);
      lin_in = (lin_w > 20'(gtg_pkg::LinMax)) ? gtg_pkg::LinMax : lin_w[17:0];
      brg   = (in_vec.z + 28'sd8) >>> 4;
      ang_w = (21'(brg) - 21'(in_side.heading)) <<< 2;
      if (ang_w > gtg_pkg::AngMax)      ang_in = 19'(gtg_pkg::AngMax);
      else if (ang_w < gtg_pkg::AngMin) ang_in = 19'(gtg_pkg::AngMin);
      else                              ang_in = ang_w[18:0];
      if (in_side.arrived) begin
         lin_in = '0;
         ang_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      lin_ff <= lin_in;
      ang_ff <= ang_in;
      arr_ff <= in_side.arrived;
   end

   assign out_valid   = valid_ff;
   assign linear_cmd  = lin_ff;
   assign angular_cmd = ang_ff;
   assign arrived     = arr_ff;

endmodule

FILE: sv/go_to_goal_p_controller.sv
// Top level of the pipelined proportional go-to-goal controller.
//
//   channel   direction  handshake            payload
//   request   in         req_start / req_busy req_pose_x, req_pose_y, req_pose_heading
//   response  out        rsp_strobe           rsp_linear_cmd, rsp_angular_cmd, rsp_arrived
//   config    in         csr_psel/penable     csr_paddr, csr_pwdata -> csr_prdata
//
// One pose enters every cycle; req_busy is held low. Each beat passes through
// three entry stages (offsets and squares, sum, tolerance compare and
// pre-rotation), sixteen CORDIC stages that also carry the 18 digits of the
// integer square root, two digits in each of the first nine, and one output
// stage. Reset drops every valid bit and restores the goal and tolerance registers.
// The receiver cannot stall, so the pipeline simply advances every cycle.
module go_to_goal_p_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  logic signed [15:0] req_pose_x,
   input  logic signed [15:0] req_pose_y,
   input  logic signed [15:0] req_pose_heading,
   output logic               rsp_strobe,
   output logic [17:0]        rsp_linear_cmd,
   output logic signed [18:0] rsp_angular_cmd,
   output logic               rsp_arrived,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int N = gtg_pkg::CordicIters;

   logic signed [15:0] goal_x_ff, goal_y_ff;
   logic [15:0]        tol_ff;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign req_busy   = 1'b0;
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // register file: unknown addresses ignore writes and read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= gtg_pkg::GoalXReset;
         goal_y_ff <= gtg_pkg::GoalYReset;
         tol_ff    <= gtg_pkg::TolReset;
      end else if (wr_en && csr_paddr[1:0] == 2'b00) begin
         case (reg_idx)
            gtg_pkg::RegGoalX: goal_x_ff <= csr_pwdata[15:0];
            gtg_pkg::RegGoalY: goal_y_ff <= csr_pwdata[15:0];
            gtg_pkg::RegTol:   tol_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (reg_idx)
            gtg_pkg::RegGoalX: csr_prdata = {{16{goal_x_ff[15]}}, goal_x_ff};
            gtg_pkg::RegGoalY: csr_prdata = {{16{goal_y_ff[15]}}, goal_y_ff};
            gtg_pkg::RegTol:   csr_prdata = {16'd0, tol_ff};
            default:           csr_prdata = '0;
         endcase
      end
   end

   logic                v   [N+1];
   gtg_pkg::cordic_type vec [N+1];
   gtg_pkg::sqrt_type   sq  [N+1];
   gtg_pkg::side_type   sd  [N+1];

   gtg_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_start),
      .pose_x(req_pose_x), .pose_y(req_pose_y), .pose_heading(req_pose_heading),
      .goal_x(goal_x_ff), .goal_y(goal_y_ff), .tol(tol_ff),
      .out_valid(v[0]), .out_vec(vec[0]), .out_sqrt(sq[0]), .out_side(sd[0])
   );

   // sixteen rotations; the first nine also extract two root digits each
   for (genvar i = 0; i < N; i++) begin : g_rot
      gtg_pkg::sqrt_type mid;
      logic [19:0] rs;
      logic [19:0] tr;
      always_comb begin
         mid = sq[i];
         rs  = {sq[i].rem[17:0], sq[i].rad[35:34]};
         tr  = {sq[i].root, 2'b01};
         if (i < gtg_pkg::SqrtStages) begin
            mid.rad = {sq[i].rad[33:0], 2'b00};
            if (rs >= tr) begin
               mid.rem  = rs - tr;
               mid.root = {sq[i].root[16:0], 1'b1};
            end else begin
               mid.rem  = rs;
               mid.root = {sq[i].root[16:0], 1'b0};
            end
         end
      end
      gtg_cordic_stage #(.Iter(i)) u_stage (
         .clock(clock), .reset(reset), .in_valid(v[i]),
         .in_vec(vec[i]), .in_sqrt(mid), .in_side(sd[i]),
         .out_valid(v[i+1]), .out_vec(vec[i+1]), .out_sqrt(sq[i+1]),
         .out_side(sd[i+1])
      );
   end

   gtg_back u_back (
      .clock(clock), .reset(reset), .in_valid(v[N]),
      .in_vec(vec[N]), .in_sqrt(sq[N]), .in_side(sd[N]),
      .out_valid(rsp_strobe), .linear_cmd(rsp_linear_cmd),
      .angular_cmd(rsp_angular_cmd), .arrived(rsp_arrived)
   );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the pipelined go-to-goal controller.
module tb_top;

   localparam int Latency   = 20;
   localparam int DrainWait = Latency + 10;
   localparam int CycleCap  = 400000;

   // Register byte addresses: one 32-bit word per register, plus an unmapped word.
   localparam logic [3:0] AddrGoalX = 4'(gtg_pkg::RegGoalX) << 2;
   localparam logic [3:0] AddrGoalY = 4'(gtg_pkg::RegGoalY) << 2;
   localparam logic [3:0] AddrTol   = 4'(gtg_pkg::RegTol) << 2;
   localparam logic [3:0] AddrSpare = 4'd12;

   typedef struct {
      logic [17:0]        lin;
      logic signed [18:0] ang;
      logic               arr;
   } command_type;

   // Predicts the command for every accepted pose and checks what comes out.
   class command_scoreboard;
      longint       goal_x, goal_y, tol;
      command_type  pending[$];
      int           errors;

      function new();
         goal_x = gtg_pkg::GoalXReset;
         goal_y = gtg_pkg::GoalYReset;
         tol    = gtg_pkg::TolReset;
         errors = 0;
      endfunction

      function void set_reg(logic [3:0] addr, logic [31:0] data);
         if (addr == AddrGoalX)      goal_x = longint'($signed(data[15:0]));
         else if (addr == AddrGoalY) goal_y = longint'($signed(data[15:0]));
         else if (addr == AddrTol)   tol    = longint'(data[15:0]);
      endfunction

      function longint unsigned int_root(longint unsigned n);
         longint unsigned res, b;
         res = 0;
         b   = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n   = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      // Bearing in Q.16 radians by CORDIC vectoring with floor shifts.
      function longint heading_to_goal(longint dx, longint dy);
         longint x, y, z, t, xs, ys;
         x = dx * 256;
         y = dy * 256;
         z = 0;
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y;  y = -t; z = gtg_pkg::HalfPiQ16;
            end else begin
               x = -y; y = t;  z = -gtg_pkg::HalfPiQ16;
            end
         end
         for (int i = 0; i < gtg_pkg::CordicIters; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys; y = y - xs; z = z + gtg_pkg::atan_q16(4'(i));
            end else begin
               x = x - ys; y = y + xs; z = z - gtg_pkg::atan_q16(4'(i));
            end
         end
         return z;
      endfunction

      function void note_pose(logic signed [15:0] px, logic signed [15:0] py,
                              logic signed [15:0] hd);
         longint          dx, dy, brg, ang;
         longint unsigned sq, lin;
         command_type     c;
         dx = goal_x - longint'(px);
         dy = goal_y - longint'(py);
         sq = longint'(dx * dx + dy * dy);
         if (sq <= longint'(tol * tol)) begin
            c.lin = '0; c.ang = '0; c.arr = 1'b1;
         end else begin
            lin = (3 * int_root(sq)) >> 1;
            if (lin > gtg_pkg::LinMax) lin = gtg_pkg::LinMax;
            brg = (heading_to_goal(dx, dy) + 8) >>> 4;
            ang = 4 * (brg - longint'(hd));
            if (ang > gtg_pkg::AngMax) ang = gtg_pkg::AngMax;
            if (ang < gtg_pkg::AngMin) ang = gtg_pkg::AngMin;
            c.lin = 18'(lin); c.ang = 19'(ang); c.arr = 1'b0;
         end
         pending.push_back(c);
      endfunction

      function void check_command(logic [17:0] lin, logic signed [18:0] ang, logic arr);
         command_type e;
         if (pending.size() == 0) begin
            $error("unexpected beat: linear_cmd=%0d angular_cmd=%0d arrived=%0b",
                   lin, ang, arr);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (lin !== e.lin) begin
            $error("linear_cmd: expected %0d, got %0d", e.lin, lin);
            errors++;
         end
         if (ang !== e.ang) begin
            $error("angular_cmd: expected %0d, got %0d", e.ang, ang);
            errors++;
         end
         if (arr !== e.arr) begin
            $error("arrived: expected %0b, got %0b", e.arr, arr);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_start = 1'b0;
   logic               req_busy;
   logic signed [15:0] req_pose_x = '0;
   logic signed [15:0] req_pose_y = '0;
   logic signed [15:0] req_pose_heading = '0;
   logic               rsp_strobe;
   logic [17:0]        rsp_linear_cmd;
   logic signed [18:0] rsp_angular_cmd;
   logic               rsp_arrived;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   command_scoreboard sb = new();
   logic              took = 1'b0;
   int                cycles = 0;
   bit                quiet = 0;

   always #5 clock = ~clock;

   go_to_goal_p_controller DUT (.*);

   // Sample both channels on the rising edge; inputs only move on the falling edge.
   always @(posedge clock) begin
      took <= req_start && !req_busy && !reset;
      if (!reset) begin
         if (req_start && !req_busy) sb.note_pose(req_pose_x, req_pose_y, req_pose_heading);
         if (rsp_strobe) sb.check_command(rsp_linear_cmd, rsp_angular_cmd, rsp_arrived);
      end
   end

   // Watchdog: give up if the run stalls far beyond its worst case.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Present one pose and hold it until a beat is taken.
   task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] hd);
      req_pose_x       = px;
      req_pose_y       = py;
      req_pose_heading = hd;
      req_start        = 1'b1;
      do @(negedge clock); while (!took);
   endtask

   task automatic hold_off(int n);
      req_start = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Random idle bursts between beats, none once quiet is set.
   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 19));
   endtask

   task automatic write_reg(logic [3:0] addr, logic [31:0] data);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      sb.set_reg(addr, data);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Drain the pipeline so a register write cannot touch a pose in flight.
   task automatic drain();
      hold_off(1);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DrainWait) @(negedge clock);
   endtask

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return 16'(v);
   endfunction

   // Mostly full-range poses, with a share landing close to the goal.
   task automatic random_poses(int n);
      longint r;
      for (int i = 0; i < n; i++) begin
         maybe_idle();
         if ($urandom_range(0, 3) == 0) begin
            r = (sb.tol > 200) ? 200 : sb.tol + 4;
            send_pose(clamp16(sb.goal_x + $signed($urandom_range(0, 2 * r)) - r),
                      clamp16(sb.goal_y + $signed($urandom_range(0, 2 * r)) - r),
                      16'($urandom));
         end else begin
            send_pose(16'($urandom), 16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed: reset goal (1.0, 1.0), tolerance 3.
      send_pose(16'sd256, 16'sd256, 16'sd0);         // zero offset
      send_pose(16'sd258, 16'sd256, 16'sd0);         // inside tolerance
      send_pose(16'sd259, 16'sd256, 16'sd0);         // on the tolerance edge
      send_pose(16'sd260, 16'sd256, 16'sd0);         // just outside
      send_pose(-16'sd32768, -16'sd32768, -16'sd32768);
      send_pose(16'sd32767, 16'sd32767, 16'sd32767);
      send_pose(16'sd32767, -16'sd32768, 16'sd0);
      send_pose(-16'sd32768, 16'sd32767, 16'sd0);
      send_pose(16'sd1000, 16'sd0, 16'sd100);        // pre-rotation, y >= 0
      send_pose(16'sd1000, 16'sd1000, -16'sd100);    // pre-rotation, y < 0
      send_pose(16'sd1000, 16'sd256, 16'sd0);        // straight behind
      send_pose(16'sd0, 16'sd256, 16'sd0);           // straight ahead
      send_pose(16'sd256, 16'sd0, 16'sd0);           // straight up
      send_pose(16'sd256, 16'sd1000, 16'sd0);        // straight down
      send_pose(16'sd0, -16'sd30000, -16'sd32768);   // large positive angular, no clip
      send_pose(16'sd0, 16'sd30000, 16'sd32767);     // large negative angular, no clip
      drain();

      // Goal at the extremes, zero tolerance; the unmapped word must be ignored.
      write_reg(AddrGoalX, 32'h0000_8000);
      write_reg(AddrGoalY, 32'h0000_7FFF);
      write_reg(AddrTol, 32'h0000_0000);
      write_reg(AddrSpare, 32'hFFFF_FFFF);
      drain();
      send_pose(-16'sd32768, 16'sd32767, 16'sd0);    // zero offset, zero tolerance
      send_pose(16'sd32767, -16'sd32768, 16'sd0);
      send_pose(-16'sd32767, 16'sd32767, 16'sd0);
      random_poses(110);
      drain();

      // Widest tolerance: most poses count as arrived.
      write_reg(AddrGoalX, 32'h0000_7FFF);
      write_reg(AddrGoalY, 32'h0000_8000);
      write_reg(AddrTol, 32'h0000_FFFF);
      drain();
      send_pose(-16'sd32768, 16'sd32767, 16'sd0);
      random_poses(100);
      drain();

      // Random settings; upper data bits carry junk that must be dropped.
      for (int p = 0; p < 6; p++) begin
         write_reg(AddrGoalX, $urandom);
         write_reg(AddrGoalY, $urandom);
         write_reg(AddrTol, (p % 2) ? $urandom : $urandom_range(0, 2000));
         drain();
         if (p == 5) quiet = 1;
         random_poses(100);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

FILE: filelist.f
sv/gtg_pkg.sv
sv/gtg_cordic_stage.sv
sv/gtg_front.sv
sv/gtg_back.sv
sv/go_to_goal_p_controller.sv
dv/tb_top.sv
